>>> rtl/hcu8_pkg.sv
// ----------------------------------------------------------------------------
// hcu8_pkg: shared types and constants for the hex code point to UTF-8 unit
// Holds the parser-to-encoder record and the scalar range limits.
// ----------------------------------------------------------------------------
package hcu8_pkg;

  localparam int unsigned MAX_DIGITS = 6;
  localparam int unsigned DIG_W      = 3;
  localparam int unsigned ACC_W      = 24;
  localparam int unsigned CP_W       = 21;

  localparam logic [ACC_W-1:0] MAX_SCALAR = 24'h10FFFF;
  localparam logic [ACC_W-1:0] SURR_LO    = 24'h00D800;
  localparam logic [ACC_W-1:0] SURR_HI    = 24'h00DFFF;
  localparam logic [7:0]       PLUS_CHAR  = 8'h2B;

  // configuration register indexes
  localparam logic REG_RESULT_LIMIT = 1'b0;

  // one finished string, handed from parser to encoder
  typedef struct packed {
    logic            scalar_ok;   // digits valid and value is a scalar
    logic [CP_W-1:0] code_point;
    logic [DIG_W-1:0] digits;
  } str_rec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/hcu8_front.sv
// ----------------------------------------------------------------------------
// hcu8_front: character parser
// Accepts one character a cycle unless the queue is full, gathers hex
// digits, and on a string's last character pushes one record to the queue.
// ----------------------------------------------------------------------------
module hcu8_front
  import hcu8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] char_byte,
  input  logic      last_char,
  input  q_stat_t   q_stat,
  output logic      push,
  output str_rec_t  push_rec
);

  logic [ACC_W-1:0] accumulator;
  logic [DIG_W-1:0] digits_seen;
  logic             at_start;
  logic             bad_string;

  logic [ACC_W-1:0] accumulator_next;
  logic [DIG_W-1:0] digits_seen_next;
  logic             bad_string_next;
  logic             is_hex;
  logic             is_letter;
  logic [3:0]       digit;
  logic             skip_plus;
  logic             take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  // classify the character
  always_comb begin
    is_hex    = 1'b0;
    is_letter = 1'b0;
    if (char_byte inside {[8'h30:8'h39]}) begin
      is_hex = 1'b1;
    end else if (char_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      is_hex    = 1'b1;
      is_letter = 1'b1;
    end
    digit = is_letter ? (char_byte[3:0] + 4'd9) : char_byte[3:0];
  end

  assign skip_plus = at_start && (char_byte == PLUS_CHAR);

  // digit gathering
  always_comb begin
    accumulator_next = accumulator;
    digits_seen_next = digits_seen;
    bad_string_next  = bad_string;
    if (!skip_plus) begin
      if (!is_hex) begin
        bad_string_next = 1'b1;
      end else if (digits_seen == DIG_W'(MAX_DIGITS)) begin
        bad_string_next = 1'b1;
      end else begin
        accumulator_next = {accumulator[ACC_W-5:0], digit};
        digits_seen_next = digits_seen + 1'b1;
      end
    end
  end

  // record for the encoder
  always_comb begin
    push_rec.scalar_ok  = !bad_string_next && (digits_seen_next != '0) &&
                          (accumulator_next <= MAX_SCALAR) &&
                          ((accumulator_next < SURR_LO) || (accumulator_next > SURR_HI));
    push_rec.code_point = accumulator_next[CP_W-1:0];
    push_rec.digits     = digits_seen_next;
  end

  assign push = take && last_char;

  // parser state; cleared after each string
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      digits_seen <= '0;
      at_start    <= 1'b1;
      bad_string  <= 1'b0;
    end else if (take) begin
      if (last_char) begin
        accumulator <= '0;
        digits_seen <= '0;
        at_start    <= 1'b1;
        bad_string  <= 1'b0;
      end else begin
        accumulator <= accumulator_next;
        digits_seen <= digits_seen_next;
        at_start    <= 1'b0;
        bad_string  <= bad_string_next;
      end
    end
  end

endmodule

>>> rtl/hcu8_queue.sv
// ----------------------------------------------------------------------------
// hcu8_queue: two-entry record queue
// Decouples the parser from the encoder so each side stalls on its own.
// ----------------------------------------------------------------------------
module hcu8_queue
  import hcu8_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  str_rec_t push_rec,
  input  logic     pop,
  output str_rec_t head_rec,
  output q_stat_t  q_stat
);

  str_rec_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head_rec     = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/hcu8_back.sv
// ----------------------------------------------------------------------------
// hcu8_back: UTF-8 encoder and output register
// Pops one record, applies the result limit, encodes and holds the result
// word until the receiver takes it.
// ----------------------------------------------------------------------------
module hcu8_back
  import hcu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  str_rec_t    head_rec,
  input  q_stat_t     q_stat,
  output logic        pop,
  input  logic [7:0]  result_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [20:0] code_point,
  output logic [31:0] utf8_bytes,
  output logic [2:0]  utf8_length,
  output logic [2:0]  digit_count
);

  logic            hit;
  logic [CP_W-1:0] cp;
  logic [31:0]     enc_bytes;
  logic [2:0]      enc_len;

  assign pop = !q_stat.empty && (!out_valid || out_ready);
  assign hit = head_rec.scalar_ok && (result_limit != 8'd0);
  assign cp  = head_rec.code_point;

  // UTF-8 encoding, first byte lowest
  always_comb begin
    if (cp < 21'h80) begin
      enc_len   = 3'd1;
      enc_bytes = {25'd0, cp[6:0]};
    end else if (cp < 21'h800) begin
      enc_len   = 3'd2;
      enc_bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
    end else if (cp < 21'h10000) begin
      enc_len   = 3'd3;
      enc_bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    end else begin
      enc_len   = 3'd4;
      enc_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                   5'b11110, cp[20:18]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      found       <= hit;
      code_point  <= hit ? cp : '0;
      utf8_bytes  <= hit ? enc_bytes : '0;
      utf8_length <= hit ? enc_len : '0;
      digit_count <= hit ? head_rec.digits : '0;
    end
  end

endmodule

>>> rtl/hex_codepoint_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// hex_codepoint_to_utf8_unit: hex code point parser and UTF-8 encoder
// Reads a query string one character per word, gives one result per string.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ASCII character per word in tdata[7:0]; tlast marks
//   the final character of a string. A leading '+' is skipped, then one to
//   six hex digits form the code point.
//   m_axis gives one word per string: tuser is the found flag, tdata holds
//   code point, UTF-8 bytes (first byte lowest), byte count and digit count.
//   All fields other than found are zero when the string is not found.
//   The APB port holds result_limit at address 0 (reset 1; zero suppresses
//   every match). Write it only while the block is idle.
// Timing:
//   One character is taken every cycle while a queue entry is free. The
//   accepting edge of the last character writes the two-entry record queue;
//   the output register loads the record from there once it is free.
//   When m_axis_tready is low the result holds; the parser keeps taking
//   characters until both queue entries are occupied, then drops tready.
// Reset (rst, synchronous): parser state clears, queue and output empty,
//   result_limit returns to 1.
// ----------------------------------------------------------------------------
module hex_codepoint_to_utf8_unit
  import hcu8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // last_char
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [20:0] code_point, [52:21] utf8_bytes,
                                      // [55:53] utf8_length, [58:56] digit_count
  output logic        m_axis_tuser,   // found
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  result_limit;
  logic        push;
  logic        pop;
  str_rec_t    push_rec;
  str_rec_t    head_rec;
  q_stat_t     q_stat;
  logic [20:0] code_point;
  logic [31:0] utf8_bytes;
  logic [2:0]  utf8_length;
  logic [2:0]  digit_count;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RESULT_LIMIT) ? {24'd0, result_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_limit <= 8'd1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RESULT_LIMIT)) begin
      result_limit <= pwdata[7:0];
    end
  end

  hcu8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .char_byte (s_axis_tdata),
    .last_char (s_axis_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_rec  (push_rec)
  );

  hcu8_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  hcu8_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_rec     (head_rec),
    .q_stat       (q_stat),
    .pop          (pop),
    .result_limit (result_limit),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .found        (m_axis_tuser),
    .code_point   (code_point),
    .utf8_bytes   (utf8_bytes),
    .utf8_length  (utf8_length),
    .digit_count  (digit_count)
  );

  // result word packing
  assign m_axis_tdata = {5'd0, digit_count, utf8_length, utf8_bytes, code_point};

endmodule
